>>> rtl/dq_pkg.sv
// Shared types, codes and defaults for the double-ended queue unit.
package dq_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int ELEM_BITS_DEFAULT = 8;

   localparam int CMD_BITS    = 3;
   localparam int VALUE_BITS  = 8;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 5;

   localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_INSPECT    = 3'd4;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RESP
   } dq_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // apply the word on req_ ports this cycle
      logic respond;  // result registers are valid this cycle
   } dq_ctrl_type;

endpackage

>>> rtl/dq_ctrl.sv
// Controller state machine of the double-ended queue unit.
module dq_ctrl
   import dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output dq_ctrl_type ctrl
);

   dq_state_type state_ff;
   dq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      busy         = 1'b1;
      ctrl.accept  = 1'b0;
      ctrl.respond = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctrl.accept = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // Present the result and take the next word in the same cycle.
            busy         = 1'b0;
            ctrl.respond = 1'b1;
            if (start) begin
               ctrl.accept = 1'b1;
               state_in    = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/dq_datapath.sv
// Ring-buffer storage, pointers, count and result registers of the queue.
module dq_datapath
   import dq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int ELEM_BITS = ELEM_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dq_ctrl_type            ctrl,
   input  logic [CMD_BITS-1:0]    req_cmd,
   input  logic [VALUE_BITS-1:0]  req_push_value,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic                   rsp_is_empty,
   output logic [COUNT_BITS-1:0]  rsp_entry_count,
   output logic [VALUE_BITS-1:0]  rsp_front_value,
   output logic [VALUE_BITS-1:0]  rsp_back_value
);

   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int STORE_BITS = (ELEM_BITS < VALUE_BITS) ? ELEM_BITS : VALUE_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX  = IDX_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(DEPTH);

   function automatic logic [IDX_BITS-1:0] idx_next(input logic [IDX_BITS-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_BITS-1:0] idx_prev(input logic [IDX_BITS-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   logic [STORE_BITS-1:0]  slots_ff [DEPTH];
   logic [IDX_BITS-1:0]    front_ff, front_in;
   logic [IDX_BITS-1:0]    back_ff, back_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [STORE_BITS-1:0]  rd_front_ff;
   logic [STORE_BITS-1:0]  rd_back_ff;
   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_idx;
   logic                   is_full;
   logic                   is_empty;

   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      status_in = STATUS_OK;
      wr_en     = 1'b0;
      wr_idx    = back_ff;
      case (req_cmd)
         CMD_PUSH_BACK: begin
            if (is_full) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               wr_idx   = back_ff;
               back_in  = idx_next(back_ff);
               count_in = count_ff + 1'b1;
            end
         end
         CMD_PUSH_FRONT: begin
            if (is_full) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               wr_idx   = idx_prev(front_ff);
               front_in = idx_prev(front_ff);
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (is_empty) begin
               status_in = STATUS_UNDERFLOW;
            end else begin
               front_in = idx_next(front_ff);
               count_in = count_ff - 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (is_empty) begin
               status_in = STATUS_UNDERFLOW;
            end else begin
               back_in  = idx_prev(back_ff);
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            // inspect only, and unused codes
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (ctrl.accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept && wr_en) begin
         slots_ff[wr_idx] <= STORE_BITS'(req_push_value);
      end
   end

   // Both ends are read every cycle from the current pointers.
   always_ff @(posedge clock) begin
      rd_front_ff <= slots_ff[front_ff];
      rd_back_ff  <= slots_ff[idx_prev(back_ff)];
   end

   assign rsp_status      = status_ff;
   assign rsp_is_empty    = is_empty;
   assign rsp_entry_count = COUNT_BITS'(count_ff);
   assign rsp_front_value = is_empty ? '0 : VALUE_BITS'(rd_front_ff);
   assign rsp_back_value  = is_empty ? '0 : VALUE_BITS'(rd_back_ff);

endmodule

>>> rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: controller plus ring-buffer datapath.
//
// A double-ended queue of characters in a ring buffer of DEPTH slots. A word is
// taken when start is high and busy is low; req_cmd selects push back, push
// front, pop front, pop back or inspect (unused codes inspect). Every word
// yields exactly one result, shown for one cycle with rsp_valid high in the
// response state, after the read state; the receiver cannot stall it, so sample
// it then. A pop on an empty queue reports underflow and a push on a full queue
// reports overflow; either way the queue is left as it was. Front and back
// values read 0 while the queue is empty. busy drops again in the cycle that
// shows the result, so a new word may be issued there; no new word is taken
// while the last one waits for the registered read of the slot memory.
module double_ended_queue_unit
   import dq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int ELEM_BITS = ELEM_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [CMD_BITS-1:0]    req_cmd,
   input  logic [VALUE_BITS-1:0]  req_push_value,
   output logic                   rsp_valid,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic                   rsp_is_empty,
   output logic [COUNT_BITS-1:0]  rsp_entry_count,
   output logic [VALUE_BITS-1:0]  rsp_front_value,
   output logic [VALUE_BITS-1:0]  rsp_back_value
);

   dq_ctrl_type ctrl;

   // Sequence each word: accept, wait for the registered slot reads, respond.
   dq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   // Hold the slots, pointers and count; apply a word when told to accept.
   dq_datapath #(
      .DEPTH     (DEPTH),
      .ELEM_BITS (ELEM_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_cmd         (req_cmd),
      .req_push_value  (req_push_value),
      .rsp_status      (rsp_status),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value)
   );

   assign rsp_valid = ctrl.respond;

endmodule
